[rtl/ame_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ame_pkg;

	// datapath geometry
	localparam int NUM_WORDS  = 10;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int CNT_W      = $clog2(DATA_WIDTH + 1);

	// stream field widths
	localparam int KIND_W     = 4;
	localparam int MIDX_W     = 4;
	localparam int VAL_W      = 32;
	localparam int ERR_W      = 2;
	localparam int S_TDATA_W  = 72;
	localparam int S_TUSER_W  = 5;
	localparam int M_TDATA_W  = 32;
	localparam int M_TUSER_W  = 2;

	// instruction kinds
	localparam logic [KIND_W-1:0] K_LOAD  = 4'd0;
	localparam logic [KIND_W-1:0] K_STORE = 4'd1;
	localparam logic [KIND_W-1:0] K_ADD   = 4'd2;
	localparam logic [KIND_W-1:0] K_SUB   = 4'd3;
	localparam logic [KIND_W-1:0] K_MULT  = 4'd4;
	localparam logic [KIND_W-1:0] K_DIV   = 4'd5;
	localparam logic [KIND_W-1:0] K_MOD   = 4'd6;
	localparam logic [KIND_W-1:0] K_CLEAR = 4'd7;
	localparam logic [KIND_W-1:0] K_OUT   = 4'd8;
	localparam logic [KIND_W-1:0] K_IN    = 4'd9;
	localparam logic [KIND_W-1:0] K_END   = 4'd10;

	// error codes
	localparam logic [ERR_W-1:0] ERR_NONE = 2'd0;
	localparam logic [ERR_W-1:0] ERR_ZERO = 2'd1;
	localparam logic [ERR_W-1:0] ERR_OVF  = 2'd2;

	typedef struct packed {
		logic load;       // capture the accepted beat
		logic exec;       // apply an instruction that uses neither the divider nor the output
		logic div_start;  // launch the divider
		logic div_write;  // write the signed divider result
		logic emit;       // load the output register
	} ame_cmd_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              div_zero;
		logic              div_ovf;
		logic              div_done;
		logic              out_free;
	} ame_sts_t;

endpackage

`default_nettype wire

[rtl/ame_div.sv]
`timescale 1ns / 1ps
`default_nettype none

// Unsigned restoring divider, one quotient bit per cycle.
module ame_div (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	input  wire logic [ame_pkg::DATA_WIDTH-1:0]  dividend,
	input  wire logic [ame_pkg::DATA_WIDTH-1:0]  divisor,
	output logic                                 done,
	output logic [ame_pkg::DATA_WIDTH-1:0]       quotient,
	output logic [ame_pkg::DATA_WIDTH-1:0]       remainder
);

	localparam int W = ame_pkg::DATA_WIDTH;

	logic                        busy_q;
	logic [ame_pkg::CNT_W-1:0]   cnt_q;
	logic [W-1:0]                rem_q;
	logic [W-1:0]                quo_q;
	logic [W-1:0]                dsr_q;
	logic [W:0]                  rem_sh;
	logic [W:0]                  diff;

	assign rem_sh = {rem_q, quo_q[W-1]};
	assign diff   = rem_sh - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= ame_pkg::CNT_W'(W);
		end else if (busy_q && cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q && cnt_q != '0) begin
			rem_q <= diff[W] ? rem_sh[W-1:0] : diff[W-1:0];
			quo_q <= {quo_q[W-2:0], ~diff[W]};
		end
	end

	assign done      = busy_q && (cnt_q == '0);
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

[rtl/ame_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module ame_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire ame_pkg::ame_sts_t sts,
	output ame_pkg::ame_cmd_t      cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       halted_q;
	logic       halt_set;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		halt_set = 1'b0;
		case (state_q)
			ST_IDLE: begin
				// beats that arrive after end are taken and dropped
				if (s_tvalid && !halted_q) begin
					cmd.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				case (sts.kind)
					ame_pkg::K_OUT: begin
						if (sts.out_free) begin
							cmd.emit = 1'b1;
							state_d  = ST_IDLE;
						end
					end
					ame_pkg::K_DIV, ame_pkg::K_MOD: begin
						if (sts.div_zero || sts.div_ovf) begin
							if (sts.out_free) begin
								cmd.emit = 1'b1;
								state_d  = ST_IDLE;
							end
						end else begin
							cmd.div_start = 1'b1;
							state_d       = ST_DIV;
						end
					end
					ame_pkg::K_END: begin
						halt_set = 1'b1;
						state_d  = ST_IDLE;
					end
					default: begin
						cmd.exec = 1'b1;
						state_d  = ST_IDLE;
					end
				endcase
			end
			ST_DIV: begin
				if (sts.div_done) begin
					cmd.div_write = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			halted_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (halt_set) begin
				halted_q <= 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/ame_dpath.sv]
`timescale 1ns / 1ps
`default_nettype none

module ame_dpath (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire ame_pkg::ame_cmd_t                    cmd,
	output ame_pkg::ame_sts_t                         sts,
	input  wire logic [ame_pkg::KIND_W-1:0]           kind,
	input  wire logic                                 use_memory,
	input  wire logic [ame_pkg::MIDX_W-1:0]           mem_index,
	input  wire logic signed [ame_pkg::VAL_W-1:0]     immediate,
	input  wire logic signed [ame_pkg::VAL_W-1:0]     input_value,
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	output logic signed [ame_pkg::VAL_W-1:0]          out_value,
	output logic [ame_pkg::ERR_W-1:0]                 error_code
);

	localparam int W = ame_pkg::DATA_WIDTH;

	// captured instruction
	logic [ame_pkg::KIND_W-1:0]        kind_q;
	logic                              usem_q;
	logic [ame_pkg::MIDX_W-1:0]        idx_q;
	logic signed [ame_pkg::VAL_W-1:0]  imm_q;
	logic signed [ame_pkg::VAL_W-1:0]  inv_q;

	logic [W-1:0] acc_q;
	logic [W-1:0] mem_q [ame_pkg::NUM_WORDS];

	logic         idx_ok;
	logic [W-1:0] opnd;
	logic [W-1:0] prod;
	logic         na;
	logic         nb;
	logic [W-1:0] ua;
	logic [W-1:0] ub;
	logic         div_done;
	logic [W-1:0] quo;
	logic [W-1:0] rem;
	logic         ovf;

	logic         m_tvalid_q;
	logic signed [ame_pkg::VAL_W-1:0] out_value_q;
	logic [ame_pkg::ERR_W-1:0]        error_code_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= kind;
			usem_q <= use_memory;
			idx_q  <= mem_index;
			imm_q  <= immediate;
			inv_q  <= input_value;
		end
	end

	assign idx_ok = ({1'b0, idx_q} < (ame_pkg::MIDX_W + 1)'(ame_pkg::NUM_WORDS));

	always_comb begin
		if (usem_q) begin
			opnd = idx_ok ? mem_q[idx_q[ame_pkg::IDX_W-1:0]] : '0;
		end else begin
			opnd = W'(imm_q);
		end
	end

	assign prod = acc_q * opnd;

	// sign handling around the unsigned divider
	assign na  = acc_q[W-1];
	assign nb  = opnd[W-1];
	assign ua  = na ? (W'(0) - acc_q) : acc_q;
	assign ub  = nb ? (W'(0) - opnd) : opnd;
	assign ovf = (acc_q == {1'b1, {(W-1){1'b0}}}) && (opnd == {W{1'b1}});

	ame_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (ua),
		.divisor   (ub),
		.done      (div_done),
		.quotient  (quo),
		.remainder (rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			for (int i = 0; i < ame_pkg::NUM_WORDS; i++) begin
				mem_q[i] <= '0;
			end
		end else if (cmd.exec) begin
			case (kind_q)
				ame_pkg::K_LOAD: acc_q <= opnd;
				ame_pkg::K_STORE: begin
					if (usem_q && idx_ok) begin
						mem_q[idx_q[ame_pkg::IDX_W-1:0]] <= acc_q;
					end
				end
				ame_pkg::K_ADD:  acc_q <= acc_q + opnd;
				ame_pkg::K_SUB:  acc_q <= acc_q - opnd;
				ame_pkg::K_MULT: acc_q <= prod;
				ame_pkg::K_CLEAR: begin
					for (int i = 0; i < ame_pkg::NUM_WORDS; i++) begin
						mem_q[i] <= '0;
					end
				end
				ame_pkg::K_IN:   acc_q <= W'(inv_q);
				default: begin
				end
			endcase
		end else if (cmd.div_write) begin
			if (kind_q == ame_pkg::K_DIV) begin
				acc_q <= (na != nb) ? (W'(0) - quo) : quo;
			end else begin
				acc_q <= na ? (W'(0) - rem) : rem;
			end
		end
	end

	// single-entry output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.emit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			if (kind_q == ame_pkg::K_OUT) begin
				out_value_q  <= ame_pkg::VAL_W'(signed'(acc_q));
				error_code_q <= ame_pkg::ERR_NONE;
			end else begin
				out_value_q  <= '0;
				error_code_q <= (opnd == '0) ? ame_pkg::ERR_ZERO : ame_pkg::ERR_OVF;
			end
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign out_value  = out_value_q;
	assign error_code = error_code_q;

	assign sts.kind     = kind_q;
	assign sts.div_zero = (opnd == '0);
	assign sts.div_ovf  = ovf;
	assign sts.div_done = div_done;
	assign sts.out_free = !m_tvalid_q || m_tready;

endmodule

`default_nettype wire

[rtl/accumulator_machine_execute.sv]
// Accumulator machine execute unit.
// Slave stream: one beat is one decoded instruction (kind and operand select in
// s_tuser; memory index, immediate and input value in s_tdata). Master stream:
// one beat per out instruction (accumulator value) or per failed div/mod
// (value zero with an error code in m_tuser); every other instruction is silent.
// Timing: s_tready is high only while the unit is idle. A beat is captured
// in the idle state and executed in the execute state; a div or mod that
// does not fail then runs a one-bit-per-cycle restoring divider in the
// divide state. Without output back-pressure, div and mod take the longest.
// An out or error result enters the output register from the execute state.
// The result sits in a one-deep output register, so the next instruction is
// accepted while a result waits; a later result-producing instruction holds in
// execute until the receiver takes the earlier beat (m_tready).
// Reset (arst_n low, asynchronous) clears the accumulator, all memory words,
// the halt flag and the output valid. After an end instruction the unit keeps
// taking beats but drops them until the next reset.
`timescale 1ns / 1ps
`default_nettype none

module accumulator_machine_execute (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	// [3:0] mem_index, [35:4] immediate, [67:36] input_value, [71:68] zero
	input  wire logic [ame_pkg::S_TDATA_W-1:0]     s_tdata,
	// [3:0] kind, [4] use_memory
	input  wire logic [ame_pkg::S_TUSER_W-1:0]     s_tuser,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// [31:0] out_value
	output logic [ame_pkg::M_TDATA_W-1:0]          m_tdata,
	// [1:0] error_code
	output logic [ame_pkg::M_TUSER_W-1:0]          m_tuser
);

	ame_pkg::ame_cmd_t cmd;
	ame_pkg::ame_sts_t sts;

	logic signed [ame_pkg::VAL_W-1:0] out_value;
	logic [ame_pkg::ERR_W-1:0]        error_code;

	// sequencing: accept, execute, divide, emit
	ame_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// accumulator, memory words, divider and output register
	ame_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.kind        (s_tuser[3:0]),
		.use_memory  (s_tuser[4]),
		.mem_index   (s_tdata[3:0]),
		.immediate   (s_tdata[35:4]),
		.input_value (s_tdata[67:36]),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.out_value   (out_value),
		.error_code  (error_code)
	);

	assign m_tdata = out_value;
	assign m_tuser = error_code;

endmodule

`default_nettype wire
